FILE: sv/fnrb_pkg.sv
// Package for the four-neighbour RGB blur: pixel types, stage control and averaging.
package fnrb_pkg;

    // Register indexes on the configuration port (taken from paddr[2])
    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    // Register widths and reset values
    localparam int unsigned IMG_W_BITS = 12;
    localparam int unsigned IMG_H_BITS = 13;
    localparam logic [IMG_W_BITS-1:0] IMAGE_WIDTH_RESET  = 12'd640;
    localparam logic [IMG_H_BITS-1:0] IMAGE_HEIGHT_RESET = 13'd480;

    // Item kind on the input stream
    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } pixel_t;

    // One line store entry: the row above and the row of the centre pixel
    typedef struct packed {
        pixel_t upper;
        pixel_t middle;
    } line_pair_t;

    // Control carried by an item from the input stage to the window stage
    typedef struct packed {
        logic flush;
        logic has_out;
        logic border;
        logic last;
    } stage_ctl_t;

    // Floor of the mean of four 8-bit samples
    function automatic logic [7:0] avg4(input logic [7:0] a, input logic [7:0] b,
                                        input logic [7:0] c, input logic [7:0] d);
        logic [9:0] sum;
        sum = 10'(a) + 10'(b) + 10'(c) + 10'(d);
        return sum[9:2];
    endfunction

endpackage

FILE: sv/fnrb_line_store.sv
// Two line stores held side by side in one memory with a registered read port.
module fnrb_line_store #(
    parameter int unsigned DEPTH = 2048,
    parameter int unsigned AW    = 11
) (
    input  logic                 clk,
    input  logic                 rd_en,
    input  logic [AW-1:0]        rd_addr,
    output fnrb_pkg::line_pair_t rd_data,
    input  logic                 wr_en,
    input  logic [AW-1:0]        wr_addr,
    input  fnrb_pkg::line_pair_t wr_data
);

    fnrb_pkg::line_pair_t mem [DEPTH];
    fnrb_pkg::line_pair_t rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, data held while no new read is issued
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: sv/fnrb_window.sv
// Window stage: three-pixel centre window, up/down neighbours, averaging and result data.
module fnrb_window (
    input  logic                 clk,
    input  logic                 en,
    input  fnrb_pkg::stage_ctl_t ctl,
    input  fnrb_pkg::pixel_t     pix,
    input  fnrb_pkg::line_pair_t rd,
    output fnrb_pkg::pixel_t     res_pix,
    output logic                 res_last
);

    fnrb_pkg::pixel_t centre_reg, right_reg;
    fnrb_pkg::pixel_t above_reg, below_reg;
    fnrb_pkg::pixel_t res_pix_reg;
    logic             res_last_reg;
    fnrb_pkg::pixel_t blur;

    // Neighbours after this item's shift: left = old centre, centre = old right,
    // right = middle line read; up and down are the values held before the shift
    always_comb
    begin
        blur.red   = fnrb_pkg::avg4(above_reg.red, below_reg.red,
                                    centre_reg.red, rd.middle.red);
        blur.green = fnrb_pkg::avg4(above_reg.green, below_reg.green,
                                    centre_reg.green, rd.middle.green);
        blur.blue  = fnrb_pkg::avg4(above_reg.blue, below_reg.blue,
                                    centre_reg.blue, rd.middle.blue);
    end

    // Window shift; the left neighbour is taken straight from the old centre
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            centre_reg <= right_reg;
            right_reg  <= rd.middle;
            above_reg  <= rd.upper;
            below_reg  <= pix;
        end
    end

    // Result data; border pixels pass the centre through
    always_ff @(posedge clk)
    begin
        if (en && ctl.has_out)
        begin
            res_pix_reg  <= ctl.border ? right_reg : blur;
            res_last_reg <= ctl.last;
        end
    end

    assign res_pix  = res_pix_reg;
    assign res_last = res_last_reg;

endmodule

FILE: sv/four_neighbour_rgb_blur.sv
// Top level of the four-neighbour RGB blur: config port, position counters, input stage.
//
//  channel   direction  handshake                 payload
//  s_*       in         s_tvalid / s_tready       s_tdata = red, green, blue; s_tuser = command
//  m_*       out        m_tvalid / m_tready       m_tdata = red, green, blue; m_tlast = frame_last
//  APB       in         psel & penable, pready=1  image_width @0x0, image_height @0x4
//
//  One item per clock while the result register is not stalled. After the item that completes
//  its neighbourhood is accepted, the input stage registers the pixel together with the line
//  store read, then the window stage averages into the result register, which holds the result.
//  The result register and the input stage part the two sides; the input stage is held
//  only while it holds a result-bearing item and the result register is stalled.
//  Reset clears counters and valid flags; line store contents are undefined until written.
//  A register write restarts the frame at row 0, column 0.
module four_neighbour_rgb_blur #(
    parameter int unsigned MAX_WIDTH  = 2048,
    parameter int unsigned MAX_HEIGHT = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,    // [7:0] red_in, [15:8] green_in, [23:16] blue_in
    input  logic        s_tuser,    // [0] command
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // [7:0] red_out, [15:8] green_out, [23:16] blue_out
    output logic        m_tlast,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int unsigned AW = $clog2(MAX_WIDTH);
    localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
    localparam int unsigned RW = $clog2(MAX_HEIGHT + 2);

    // Configuration registers
    logic [fnrb_pkg::IMG_W_BITS-1:0] image_width_reg;
    logic [fnrb_pkg::IMG_H_BITS-1:0] image_height_reg;
    logic                            cfg_wr;

    // Effective frame size
    logic [WW-1:0] eff_w;
    logic [RW-1:0] eff_h;
    logic [AW-1:0] w_m1;
    logic [RW-1:0] h_m1;

    // Position counters
    logic [AW-1:0] in_column_reg, in_column_next;
    logic [RW-1:0] in_row_reg, in_row_next;
    logic [AW-1:0] out_column_reg, out_column_next;
    logic [RW-1:0] out_row_reg, out_row_next;

    // Input stage
    logic                 s1_valid_reg;
    fnrb_pkg::stage_ctl_t s1_ctl_reg, s1_ctl_next;
    fnrb_pkg::pixel_t     s1_pix_reg;
    logic [AW-1:0]        s1_col_reg;
    logic                 out_valid_reg;

    logic                 accept, take, adv;
    logic                 is_flush, in_frame;
    fnrb_pkg::pixel_t     in_pix;
    fnrb_pkg::line_pair_t rd_pair, wr_pair;
    fnrb_pkg::pixel_t     res_pix;
    logic                 res_last;

    // APB port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= fnrb_pkg::IMAGE_WIDTH_RESET;
            image_height_reg <= fnrb_pkg::IMAGE_HEIGHT_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                fnrb_pkg::REG_IMAGE_WIDTH:
                    image_width_reg  <= pwdata[fnrb_pkg::IMG_W_BITS-1:0];
                fnrb_pkg::REG_IMAGE_HEIGHT:
                    image_height_reg <= pwdata[fnrb_pkg::IMG_H_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            fnrb_pkg::REG_IMAGE_WIDTH:
                prdata = 32'(image_width_reg);
            fnrb_pkg::REG_IMAGE_HEIGHT:
                prdata = 32'(image_height_reg);
            default:
                prdata = '0;
        endcase
    end

    // Saturate the frame size to the supported range
    always_comb
    begin
        priority if (image_width_reg < 12'd3)
            eff_w = WW'(3);
        else if (32'(image_width_reg) > MAX_WIDTH)
            eff_w = WW'(MAX_WIDTH);
        else
            eff_w = WW'(image_width_reg);

        priority if (image_height_reg < 13'd3)
            eff_h = RW'(3);
        else if (32'(image_height_reg) > MAX_HEIGHT)
            eff_h = RW'(MAX_HEIGHT);
        else
            eff_h = RW'(image_height_reg);

        w_m1 = AW'(eff_w - WW'(1));
        h_m1 = eff_h - RW'(1);
    end

    // Handshake: pixels are taken during the frame, flushes after it; the rest is dropped
    assign in_pix   = s_tdata;
    assign is_flush = (s_tuser == fnrb_pkg::CMD_FLUSH);
    assign in_frame = in_row_reg < eff_h;
    assign adv      = s1_valid_reg && (!s1_ctl_reg.has_out || !out_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || adv;
    assign accept   = s_tvalid && s_tready;
    assign take     = accept && (is_flush != in_frame);

    // Position update and control for the item being taken
    always_comb
    begin
        s1_ctl_next.flush   = is_flush;
        s1_ctl_next.has_out = (in_row_reg >= RW'(2)) ||
                              (in_row_reg == RW'(1) && in_column_reg != '0);
        s1_ctl_next.border  = (out_row_reg == '0) || (out_row_reg >= h_m1) ||
                              (out_column_reg == '0) || (out_column_reg >= w_m1);
        s1_ctl_next.last    = (out_row_reg >= h_m1) && (out_column_reg >= w_m1);

        in_column_next  = in_column_reg;
        in_row_next     = in_row_reg;
        out_column_next = out_column_reg;
        out_row_next    = out_row_reg;

        if (in_column_reg == w_m1)
        begin
            in_column_next = '0;
            in_row_next    = in_row_reg + RW'(1);
        end
        else
        begin
            in_column_next = in_column_reg + AW'(1);
        end

        if (s1_ctl_next.has_out)
        begin
            if (out_column_reg >= w_m1)
            begin
                out_column_next = '0;
                out_row_next    = out_row_reg + RW'(1);
            end
            else
            begin
                out_column_next = out_column_reg + AW'(1);
            end
        end

        // final result of the frame restarts everything
        if (s1_ctl_next.has_out && s1_ctl_next.last)
        begin
            in_column_next  = '0;
            in_row_next     = '0;
            out_column_next = '0;
            out_row_next    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_column_reg  <= '0;
            in_row_reg     <= '0;
            out_column_reg <= '0;
            out_row_reg    <= '0;
        end
        else if (cfg_wr)
        begin
            in_column_reg  <= '0;
            in_row_reg     <= '0;
            out_column_reg <= '0;
            out_row_reg    <= '0;
        end
        else if (take)
        begin
            in_column_reg  <= in_column_next;
            in_row_reg     <= in_row_next;
            out_column_reg <= out_column_next;
            out_row_reg    <= out_row_next;
        end
    end

    // Input stage valid and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
                s1_valid_reg <= 1'b1;
            else if (adv)
                s1_valid_reg <= 1'b0;

            if (adv && s1_ctl_reg.has_out)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Input stage payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_ctl_reg <= s1_ctl_next;
            s1_pix_reg <= in_pix;
            s1_col_reg <= in_column_reg;
        end
    end

    // Line stores: read at the input column, written back from the input stage as it advances
    assign wr_pair.upper  = rd_pair.middle;
    assign wr_pair.middle = s1_pix_reg;

    fnrb_line_store #(
        .DEPTH (MAX_WIDTH),
        .AW    (AW)
    ) u_line_store (
        .clk     (clk),
        .rd_en   (take),
        .rd_addr (in_column_reg),
        .rd_data (rd_pair),
        .wr_en   (adv && !s1_ctl_reg.flush),
        .wr_addr (s1_col_reg),
        .wr_data (wr_pair)
    );

    fnrb_window u_window (
        .clk      (clk),
        .en       (adv),
        .ctl      (s1_ctl_reg),
        .pix      (s1_pix_reg),
        .rd       (rd_pair),
        .res_pix  (res_pix),
        .res_last (res_last)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = res_pix;
    assign m_tlast  = res_last;

    // Checks
    a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        in_column_reg <= w_m1 && out_column_reg <= w_m1)
        else $error("column counter beyond frame width");

    a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        in_row_reg <= eff_h + RW'(1) && out_row_reg <= h_m1)
        else $error("row counter beyond frame height");

    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (take && s1_ctl_next.has_out && s1_ctl_next.last && !cfg_wr) |=>
        (in_row_reg == '0 && in_column_reg == '0 && out_row_reg == '0))
        else $error("frame did not restart after its final result");

    a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_ctl_reg.has_out && out_valid_reg && !m_tready) |=>
        (s1_valid_reg && out_valid_reg))
        else $error("item lost while result register stalled");

endmodule

FILE: test/four_neighbour_rgb_blur_tb.sv
// Self-checking testbench for the four-neighbour RGB blur: stream stimulus, prediction, checks.
module four_neighbour_rgb_blur_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned MAX_W            = 2048;
    localparam int unsigned MAX_H            = 4096;
    localparam int unsigned NO_CUT           = 32'hFFFF_FFFF;
    localparam int unsigned PIPE_SETTLE      = 8;
    localparam int unsigned END_SETTLE       = 20;
    localparam int unsigned SINK_HOLD_CYCLES = 400;
    localparam int unsigned WATCHDOG_LIMIT   = 5000;
    localparam int unsigned REPORT_LIMIT     = 40;

    // Directed 3x3 frames, raster order; each word is {blue, green, red}
    localparam logic [0:8][23:0] SAT_FRAME = {
        24'h000000, 24'hFFFFFF, 24'h123456,
        24'hFFFFFF, 24'h000000, 24'hFFFFFF,
        24'h00FF00, 24'hFFFFFF, 24'hFF0000};
    localparam logic [0:8][23:0] ALT_FRAME = {
        24'hAAAAAA, 24'h555555, 24'hAAAAAA,
        24'h555555, 24'h000000, 24'hAAAAAA,
        24'h555555, 24'hAAAAAA, 24'h555555};

    typedef struct packed {
        fnrb_pkg::pixel_t px;
        logic             last;
    } blur_result_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;     // [7:0] red, [15:8] green, [23:16] blue
    logic        s_tuser;     // [0] command
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;     // [7:0] red, [15:8] green, [23:16] blue
    logic        m_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Predictor state: line stores, positions, window and neighbour registers
    fnrb_pkg::pixel_t row_above_store [MAX_W];
    fnrb_pkg::pixel_t row_mid_store   [MAX_W];
    int unsigned      col_in, row_in, col_out, row_out;
    fnrb_pkg::pixel_t win_left, win_mid, win_right, up_px, down_px;
    logic [11:0]      cfg_width;
    logic [12:0]      cfg_height;
    blur_result_t     pending_pixels [$];

    // Run control and tallies
    int unsigned  send_idle_pct;
    int unsigned  recv_idle_pct;
    logic         hold_sink;
    int unsigned  quiet_cycles;
    int unsigned  mismatch_count;
    int unsigned  items_accepted;
    int unsigned  items_ignored;
    int unsigned  results_checked;
    int unsigned  frames_done;

    four_neighbour_rgb_blur #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    task automatic report_mismatch(input string msg);
        if (mismatch_count < REPORT_LIMIT)
            $display("%0t ns: mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    // Effective frame size after saturation
    function automatic int unsigned frame_w();
        if (cfg_width < 3) return 3;
        if (cfg_width > MAX_W) return MAX_W;
        return cfg_width;
    endfunction

    function automatic int unsigned frame_h();
        if (cfg_height < 3) return 3;
        if (cfg_height > MAX_H) return MAX_H;
        return cfg_height;
    endfunction

    function automatic void restart_positions();
        col_in  = 0;
        row_in  = 0;
        col_out = 0;
        row_out = 0;
    endfunction

    // Advance the blur model by one accepted item; queue the result it gives, if any
    function automatic void predict_item(input logic cmd, input fnrb_pkg::pixel_t px);
        int unsigned      w, h, c;
        fnrb_pkg::pixel_t up_n, down_n;
        logic             gives_result, border;
        blur_result_t     res;
        w = frame_w();
        h = frame_h();
        items_accepted++;
        // flush inside a frame, or pixel while flushing: dropped
        if ((cmd == fnrb_pkg::CMD_FLUSH) == (row_in < h))
        begin
            items_ignored++;
            return;
        end
        c = (col_in >= w) ? 0 : col_in;
        win_left  = win_mid;
        win_mid   = win_right;
        win_right = row_mid_store[c];
        up_n      = up_px;
        down_n    = down_px;
        up_px     = row_above_store[c];
        down_px   = px;
        if (cmd == fnrb_pkg::CMD_PIXEL)
        begin
            row_above_store[c] = row_mid_store[c];
            row_mid_store[c]   = px;
        end
        gives_result = (row_in >= 2) || (row_in == 1 && c >= 1);
        col_in = c + 1;
        if (col_in >= w)
        begin
            col_in = 0;
            row_in++;
        end
        if (!gives_result) return;

        border = (row_out == 0) || (row_out >= h - 1) || (col_out == 0) || (col_out >= w - 1);
        if (border)
            res.px = win_mid;
        else
        begin
            res.px.red   = 8'((int'(up_n.red) + int'(down_n.red) +
                               int'(win_left.red) + int'(win_right.red)) >> 2);
            res.px.green = 8'((int'(up_n.green) + int'(down_n.green) +
                               int'(win_left.green) + int'(win_right.green)) >> 2);
            res.px.blue  = 8'((int'(up_n.blue) + int'(down_n.blue) +
                               int'(win_left.blue) + int'(win_right.blue)) >> 2);
        end
        res.last = (row_out >= h - 1) && (col_out >= w - 1);
        pending_pixels.push_back(res);
        col_out++;
        if (col_out >= w)
        begin
            col_out = 0;
            row_out++;
        end
        if (res.last)
        begin
            frames_done++;
            restart_positions();
        end
    endfunction

    function automatic fnrb_pkg::pixel_t random_pixel();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return fnrb_pkg::pixel_t'(24'($urandom));
        endcase
    endfunction

    // Offer one item, with random idle cycles first; valid stays up after acceptance
    task automatic offer_item(input logic cmd, input fnrb_pkg::pixel_t px);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= px;
        do @(posedge clk); while (!s_tready);
        predict_item(cmd, px);
    endtask

    // Stop sending and wait for every outstanding result
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge clk);
        @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        // register taken at this edge; any write restarts the frame
        if (idx == fnrb_pkg::REG_IMAGE_WIDTH)
            cfg_width = value[11:0];
        else
            cfg_height = value[12:0];
        restart_positions();
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // Reconfigure only once the block has gone quiet
    task automatic set_frame_size(input logic [31:0] w, input logic [31:0] h);
        drain_results();
        repeat (PIPE_SETTLE) @(posedge clk);
        write_reg(fnrb_pkg::REG_IMAGE_WIDTH, w);
        write_reg(fnrb_pkg::REG_IMAGE_HEIGHT, h);
    endtask

    // One frame at the current size, optionally cut short, with dropped items mixed in
    task automatic send_frame(input int unsigned noise_pct, input int unsigned cut_at);
        int unsigned w, h;
        w = frame_w();
        h = frame_h();
        for (int unsigned i = 0; i < w * h && i < cut_at; i++)
        begin
            if ($urandom_range(99) < noise_pct)
                offer_item(fnrb_pkg::CMD_FLUSH, random_pixel());
            offer_item(fnrb_pkg::CMD_PIXEL, random_pixel());
        end
        if (cut_at < w * h) return;
        for (int unsigned j = 0; j <= w; j++)
        begin
            if ($urandom_range(99) < noise_pct)
                offer_item(fnrb_pkg::CMD_PIXEL, random_pixel());
            offer_item(fnrb_pkg::CMD_FLUSH, random_pixel());
        end
    endtask

    // Reset sizes: part of a 640-wide frame, first row results pass through
    task automatic test_reset_values();
        for (int i = 0; i < 650; i++)
            offer_item(fnrb_pkg::CMD_PIXEL, random_pixel());
        drain_results();
    endtask

    // Smallest frames with full-scale and alternating samples, dropped items included
    task automatic test_directed_frames();
        set_frame_size(3, 3);
        for (int i = 0; i < 9; i++)
        begin
            if (i == 4)
                offer_item(fnrb_pkg::CMD_FLUSH, '1);
            offer_item(fnrb_pkg::CMD_PIXEL, SAT_FRAME[i]);
        end
        offer_item(fnrb_pkg::CMD_FLUSH, '1);
        offer_item(fnrb_pkg::CMD_PIXEL, 24'hA5A5A5);
        for (int i = 0; i < 3; i++)
            offer_item(fnrb_pkg::CMD_FLUSH, '0);
        for (int i = 0; i < 9; i++)
            offer_item(fnrb_pkg::CMD_PIXEL, ALT_FRAME[i]);
        for (int i = 0; i < 4; i++)
            offer_item(fnrb_pkg::CMD_FLUSH, random_pixel());
        drain_results();
    endtask

    // A register write part way through a frame starts a fresh one
    task automatic test_frame_restart();
        set_frame_size(5, 4);
        send_frame(0, 12);
        set_frame_size(5, 4);
        send_frame(10, NO_CUT);
        drain_results();
    endtask

    // Out-of-range and full-width register values saturate
    task automatic test_register_extremes();
        set_frame_size(32'hFFFF_FFFF, 0);
        send_frame(0, 30);
        set_frame_size(2, 13'h1FFF);
        send_frame(0, 30);
        set_frame_size(0, 2);
        send_frame(0, NO_CUT);
        drain_results();
    endtask

    // Long output stall with the sender pushing, then a full drain
    task automatic test_backpressure();
        send_idle_pct = 0;
        set_frame_size(16, 8);
        hold_sink = 1'b1;
        send_frame(0, NO_CUT);
        drain_results();
        send_frame(5, NO_CUT);
        drain_results();
    endtask

    // Random frame sizes and contents; some frames cut short, some with dropped items
    task automatic test_random_frames(input int unsigned n_items, input int unsigned s_pct,
                                      input int unsigned r_pct);
        int unsigned target, w_raw, h_raw, cut;
        logic        was_cut;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        target  = items_accepted - items_ignored + n_items;
        was_cut = 1'b0;
        while (items_accepted - items_ignored < target)
        begin
            if (was_cut || $urandom_range(1) == 0)
            begin
                if ($urandom_range(9) == 0)
                    w_raw = $urandom_range(2);
                else if ($urandom_range(7) == 0)
                    w_raw = $urandom_range(48, 13);
                else
                    w_raw = $urandom_range(12, 3);
                h_raw = ($urandom_range(9) == 0) ? $urandom_range(2) : $urandom_range(7, 3);
                set_frame_size(w_raw, h_raw);
            end
            cut     = ($urandom_range(11) == 0) ? $urandom_range(frame_w() * frame_h() - 1, 1)
                                                : NO_CUT;
            was_cut = (cut != NO_CUT);
            send_frame(4, cut);
        end
        drain_results();
    endtask

    task automatic finish_run();
        drain_results();
        repeat (END_SETTLE) @(posedge clk);
        if (pending_pixels.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_pixels.size()));
        $display("Run covered %0d items (%0d dropped by the block), %0d results, %0d frames,",
                 items_accepted, items_ignored, results_checked, frames_done);
        $display("sizes 3x3 to 48 wide, saturated register values and a long output stall.");
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    endtask

    // Result sink: random ready, or a counted hold-off when asked
    initial
    begin : result_sink
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_sink)
            begin
                m_tready <= 1'b0;
                repeat (SINK_HOLD_CYCLES) @(posedge clk);
                hold_sink = 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Compare each result with the oldest prediction
    always @(posedge clk)
    begin : result_check
        blur_result_t     want;
        fnrb_pkg::pixel_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = fnrb_pkg::pixel_t'(m_tdata);
            if (pending_pixels.size() == 0)
                report_mismatch($sformatf("unexpected result %06h last %0b", m_tdata, m_tlast));
            else
            begin
                want = pending_pixels.pop_front();
                if (got.red !== want.px.red)
                    report_mismatch($sformatf("result %0d red %02h, want %02h",
                                              results_checked, got.red, want.px.red));
                if (got.green !== want.px.green)
                    report_mismatch($sformatf("result %0d green %02h, want %02h",
                                              results_checked, got.green, want.px.green));
                if (got.blue !== want.px.blue)
                    report_mismatch($sformatf("result %0d blue %02h, want %02h",
                                              results_checked, got.blue, want.px.blue));
                if (m_tlast !== want.last)
                    report_mismatch($sformatf("result %0d frame_last %0b, want %0b",
                                              results_checked, m_tlast, want.last));
            end
            results_checked++;
        end
    end

    // Watchdog on cycles with no handshake on any port
    always @(posedge clk)
    begin : watchdog
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t ns: no handshake for %0d cycles", $time, quiet_cycles);
            $display("Verification failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin : stimulus
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= fnrb_pkg::CMD_PIXEL;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        hold_sink       = 1'b0;
        send_idle_pct   = 6;
        recv_idle_pct   = 78;
        mismatch_count  = 0;
        items_accepted  = 0;
        items_ignored   = 0;
        results_checked = 0;
        frames_done     = 0;
        cfg_width  = fnrb_pkg::IMAGE_WIDTH_RESET;
        cfg_height = fnrb_pkg::IMAGE_HEIGHT_RESET;
        for (int i = 0; i < MAX_W; i++)
        begin
            row_above_store[i] = '0;
            row_mid_store[i]   = '0;
        end
        win_left  = '0;
        win_mid   = '0;
        win_right = '0;
        up_px     = '0;
        down_px   = '0;
        restart_positions();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_values();
        test_directed_frames();
        test_frame_restart();
        test_register_extremes();
        test_random_frames(120, 6, 78);
        test_random_frames(120, 78, 6);
        test_backpressure();
        test_random_frames(120, 0, 0);
        finish_run();
    end

endmodule
